// ===== rtl/core/upcs_pkg.sv =====
`timescale 1ns / 1ps

package upcs_pkg;

  // ranging sequence phases
  typedef enum logic [2:0] {
    PH_SETTLE = 3'd0,
    PH_PULSE  = 3'd1,
    PH_WAIT   = 3'd2,
    PH_WIDTH  = 3'd3,
    PH_PAUSE  = 3'd4
  } phase_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_STOP_MM    = 3'd0,
    REG_CLEAR_MM   = 3'd1,
    REG_TIMEOUT_US = 3'd2,
    REG_PAUSE_US   = 3'd3,
    REG_TRIGGER_US = 3'd4,
    REG_SETTLE_US  = 3'd5
  } reg_idx_e;

  localparam int unsigned MM_W       = 13;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned PAUSE_W    = 20;
  localparam int unsigned TICK8_W    = 8;
  localparam int unsigned CFG_DATA_W = 20;

  // echo width in us to mm: (w * 11239) >> 16
  localparam logic [13:0] MM_SCALE = 14'd11239;
  localparam int unsigned MM_SHIFT = 16;

  // register reset values
  localparam logic [MM_W-1:0]      STOP_MM_RST    = 13'd150;
  localparam logic [MM_W-1:0]      CLEAR_MM_RST   = 13'd200;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_US_RST = 16'd25000;
  localparam logic [PAUSE_W-1:0]   PAUSE_US_RST   = 20'd50000;
  localparam logic [TICK8_W-1:0]   TRIGGER_US_RST = 8'd10;
  localparam logic [TICK8_W-1:0]   SETTLE_US_RST  = 8'd2;

  typedef struct packed {
    logic [MM_W-1:0]      stop_mm;
    logic [MM_W-1:0]      clear_mm;
    logic [TIMEOUT_W-1:0] echo_limit_us;
    logic [PAUSE_W-1:0]   pause_us;
    logic [TICK8_W-1:0]   trigger_us;
    logic [TICK8_W-1:0]   settle_us;
  } cfg_t;

  typedef struct packed {
    logic            trigger_one;
    logic            trigger_two;
    logic            stop_flag;
    logic            reading_done;
    logic            reading_sensor;
    logic [MM_W-1:0] distance_mm;
    logic            distance_valid;
  } result_t;

endpackage

// ===== rtl/core/upcs_core.sv =====
`timescale 1ns / 1ps

module upcs_core #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_en_i,
  input  logic [1:0]        echo_i,
  input  upcs_pkg::cfg_t    cfg_i,
  output upcs_pkg::result_t res_o
);

  localparam int unsigned WW = (COUNT_WIDTH > upcs_pkg::PAUSE_W) ?
                               COUNT_WIDTH : upcs_pkg::PAUSE_W;
  localparam int unsigned PW = COUNT_WIDTH + 14;
  localparam int unsigned MM_TOP = upcs_pkg::MM_SHIFT + upcs_pkg::MM_W;

  upcs_pkg::phase_e       phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic                   active_q, active_d;
  logic [upcs_pkg::MM_W-1:0] first_mm_q, first_mm_d;
  logic                   first_vld_q, first_vld_d;
  logic                   stop_q, stop_d;

  logic                   echo;
  logic [COUNT_WIDTH-1:0] elapsed;
  logic                   at_max;
  logic                   settle_end, pulse_end, pause_end, timed_out;
  logic [PW-1:0]          prod;
  logic [upcs_pkg::MM_W-1:0] width_mm;
  logic                   trig, done, valid, close, stop_set;
  logic [upcs_pkg::MM_W-1:0] mm;

  // echo of the polled sensor and saturating tick count
  assign echo    = active_q ? echo_i[1] : echo_i[0];
  assign at_max  = &tick_q;
  assign elapsed = at_max ? tick_q : tick_q + COUNT_WIDTH'(1);

  // length compares, lengths clamped to the counter range
  assign settle_end = (WW'(elapsed) >= WW'(cfg_i.settle_us))  || (&elapsed);
  assign pulse_end  = (WW'(elapsed) >= WW'(cfg_i.trigger_us)) || (&elapsed);
  assign pause_end  = (WW'(elapsed) >= WW'(cfg_i.pause_us))   || (&elapsed);
  assign timed_out  = (WW'(elapsed) > WW'(cfg_i.echo_limit_us)) || (&elapsed);

  // width to millimetres, saturated
  assign prod     = PW'(elapsed) * PW'(upcs_pkg::MM_SCALE);
  assign width_mm = (|prod[PW-1:MM_TOP]) ? '1 : prod[MM_TOP-1:upcs_pkg::MM_SHIFT];

  // phase sequencing
  always_comb begin
    phase_d = phase_q;
    tick_d  = elapsed;
    active_d = active_q;
    trig  = 1'b0;
    done  = 1'b0;
    valid = 1'b0;
    mm    = '0;
    unique case (phase_q)
      upcs_pkg::PH_PULSE: begin
        trig = 1'b1;
        if (pulse_end) begin
          phase_d = upcs_pkg::PH_WAIT;
          tick_d  = '0;
        end
      end
      upcs_pkg::PH_WAIT: begin
        if (echo) begin
          phase_d = upcs_pkg::PH_WIDTH;
          tick_d  = '0;
        end else if (timed_out) begin
          done = 1'b1;
        end
      end
      upcs_pkg::PH_WIDTH: begin
        if (!echo) begin
          mm    = width_mm;
          valid = 1'b1;
          done  = 1'b1;
        end else if (timed_out) begin
          done = 1'b1;
        end
      end
      upcs_pkg::PH_PAUSE: begin
        if (pause_end) begin
          active_d = ~active_q;
          phase_d  = upcs_pkg::PH_SETTLE;
          tick_d   = '0;
        end
      end
      default: begin
        // settle, and any unused code behaves as settle
        if (settle_end) begin
          phase_d = upcs_pkg::PH_PULSE;
          tick_d  = '0;
        end else begin
          phase_d = upcs_pkg::PH_SETTLE;
        end
      end
    endcase
    if (done) begin
      phase_d = upcs_pkg::PH_PAUSE;
      tick_d  = '0;
    end
  end

  // stop hysteresis and first sensor memory
  always_comb begin
    close       = valid && (mm <= cfg_i.stop_mm);
    stop_set    = stop_q || close;
    stop_d      = stop_q;
    first_mm_d  = first_mm_q;
    first_vld_d = first_vld_q;
    if (done) begin
      stop_d = stop_set;
      if (!active_q) begin
        first_mm_d  = mm;
        first_vld_d = valid;
      end else if (stop_set && (!first_vld_q || (first_mm_q > cfg_i.clear_mm)) &&
                   (!valid || (mm > cfg_i.clear_mm))) begin
        stop_d = 1'b0;
      end
    end
  end

  // state registers, advanced once per processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= upcs_pkg::PH_SETTLE;
      tick_q      <= '0;
      active_q    <= 1'b0;
      first_mm_q  <= '0;
      first_vld_q <= 1'b0;
      stop_q      <= 1'b0;
    end else if (step_en_i) begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      active_q    <= active_d;
      first_mm_q  <= first_mm_d;
      first_vld_q <= first_vld_d;
      stop_q      <= stop_d;
    end
  end

  // result of this tick
  always_comb begin
    res_o.trigger_one    = trig && !active_q;
    res_o.trigger_two    = trig && active_q;
    res_o.stop_flag      = stop_d;
    res_o.reading_done   = done;
    res_o.reading_sensor = done && active_q;
    res_o.distance_mm    = mm;
    res_o.distance_valid = valid;
  end

  // checks
  a_one_trigger: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_o.trigger_one && res_o.trigger_two))
    else $error("both triggers driven");

  a_mm_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.distance_mm != '0) |-> res_o.distance_valid)
    else $error("distance without valid reading");

  a_valid_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.distance_valid |-> res_o.reading_done)
    else $error("valid outside completed reading");

  a_pause_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && res_o.reading_done) |=> (phase_q == upcs_pkg::PH_PAUSE))
    else $error("no pause after reading");

endmodule

// ===== rtl/core/ultrasonic_pair_collision_stop.sv =====
`timescale 1ns / 1ps
// Two-sensor ultrasonic collision stop.
// Slave stream: one request per microsecond tick; tdata carries both echo
// levels. Master stream: one result per tick with trigger drives, stop flag
// and, on the tick a reading completes, its distance; tuser names the sensor.
// Config channel: cfg_addr_i selects stop_mm, clear_mm, echo_limit_us,
// pause_us, trigger_us, settle_us (0..5); write only while the block is idle.
// Path: a tick is held in an input register, processed combinationally by the
// sequencer and placed in the output register, from which its result is
// presented to the receiver and can be taken.
// One tick per cycle is sustained while the receiver takes results: the input
// register frees as the output register loads or drains.
// Reset puts the configuration registers at their defaults, the sequencer in
// the settle phase of sensor one and clears the stop flag.
// When the receiver stalls, the output register holds its result and the
// input register takes one more tick; tready then drops until the stall ends.
// No tick is dropped, so the sequencer only advances on ticks it receives.
module ultrasonic_pair_collision_stop #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] echo_one, [1] echo_two
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] trigger_one, [1] trigger_two, [2] stop_flag, [3] reading_done,
  // [16:4] distance_mm, [17] distance_valid
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] reading_sensor
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [upcs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  upcs_pkg::cfg_t    cfg_q;
  upcs_pkg::result_t res;
  upcs_pkg::result_t out_q;
  logic              in_vld_q, out_vld_q;
  logic [1:0]        in_echo_q;
  logic              advance;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_mm         <= upcs_pkg::STOP_MM_RST;
      cfg_q.clear_mm        <= upcs_pkg::CLEAR_MM_RST;
      cfg_q.echo_limit_us   <= upcs_pkg::TIMEOUT_US_RST;
      cfg_q.pause_us        <= upcs_pkg::PAUSE_US_RST;
      cfg_q.trigger_us      <= upcs_pkg::TRIGGER_US_RST;
      cfg_q.settle_us       <= upcs_pkg::SETTLE_US_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        upcs_pkg::REG_STOP_MM:    cfg_q.stop_mm <= cfg_data_i[upcs_pkg::MM_W-1:0];
        upcs_pkg::REG_CLEAR_MM:   cfg_q.clear_mm <= cfg_data_i[upcs_pkg::MM_W-1:0];
        upcs_pkg::REG_TIMEOUT_US: begin
          cfg_q.echo_limit_us <= cfg_data_i[upcs_pkg::TIMEOUT_W-1:0];
        end
        upcs_pkg::REG_PAUSE_US:   cfg_q.pause_us <= cfg_data_i[upcs_pkg::PAUSE_W-1:0];
        upcs_pkg::REG_TRIGGER_US: cfg_q.trigger_us <= cfg_data_i[upcs_pkg::TICK8_W-1:0];
        upcs_pkg::REG_SETTLE_US:  cfg_q.settle_us <= cfg_data_i[upcs_pkg::TICK8_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: process the held tick when the output register can take it
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_echo_q <= s_axis_tdata[1:0];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  upcs_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_en_i(advance),
    .echo_i   (in_echo_q),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  // output packing
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.reading_sensor;
  assign m_axis_tdata  = {6'b0, out_q.distance_valid, out_q.distance_mm,
                          out_q.reading_done, out_q.stop_flag,
                          out_q.trigger_two, out_q.trigger_one};

endmodule
